### rtl/tgq_pkg.sv
// ----------------------------------------------------------------------------
// tgq_pkg: shared types and constants of the team grouped queue
// Request and status codes, widths, and the front-to-back command struct.
// ----------------------------------------------------------------------------
package tgq_pkg;
	localparam int ID_SPACE = 1024;
	localparam int TEAMS    = 64;
	localparam int CAPACITY = 256;

	localparam int ID_W   = 10;
	localparam int TEAM_W = $clog2(TEAMS);
	localparam int SLOT_W = $clog2(CAPACITY);
	localparam int CNT_W  = SLOT_W + 1;
	localparam int ORD_W  = TEAM_W + 1;

	typedef enum logic [1:0] {
		REQ_ASSIGN  = 2'd0,
		REQ_ENQUEUE = 2'd1,
		REQ_DEQUEUE = 2'd2,
		REQ_CLEAR   = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// classified command handed from the front to the back
	typedef struct packed {
		req_t              req;
		logic [ID_W-1:0]   id;
		logic [TEAM_W-1:0] team;
	} cmd_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_EXEC,
		BK_FETCH,
		BK_LINK
	} bk_state_t;
endpackage

### rtl/tgq_front.sv
// ----------------------------------------------------------------------------
// tgq_front: request intake and team lookup
// Holds the id-to-team map, applies assigns, tags every request with its team
// and passes it into a two-entry queue toward the back end. The map is zeroed
// by a clearing pass over all ID_SPACE entries after reset, with busy held high.
// ----------------------------------------------------------------------------
module tgq_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  tgq_pkg::req_t req_type,
	input  logic [9:0]    member_id,
	input  logic [5:0]    team_index,
	output logic          q_valid,
	output tgq_pkg::cmd_t q_cmd,
	input  logic          q_pop
);
	import tgq_pkg::*;

	logic [TEAM_W-1:0] map_mem [ID_SPACE];

	// clearing pass over the map after reset
	logic              clr_q;
	logic [ID_W-1:0]   clr_idx_q;

	// lookup stage
	logic              look_s1;
	req_t              req_s1;
	logic [ID_W-1:0]   id_s1;
	logic [TEAM_W-1:0] rd_s1;

	cmd_t   fifo_q [2];
	logic   wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;

	logic acc, push;
	assign acc  = start && !busy;
	// keep room for the item under lookup
	assign busy = clr_q || look_s1 || (cnt_q == 2'd2) || (cnt_q == 2'd1 && !q_pop);

	always_ff @(posedge clk) begin
		if (clr_q)
			map_mem[clr_idx_q] <= '0;
		else if (acc && req_type == REQ_ASSIGN)
			map_mem[member_id] <= team_index;
		rd_s1 <= map_mem[member_id];
		req_s1 <= req_type;
		id_s1 <= member_id;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= 1'b1;
			clr_idx_q <= '0;
			look_s1 <= 1'b0;
		end else begin
			look_s1 <= acc;
			if (clr_q) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (clr_idx_q == ID_W'(ID_SPACE - 1))
					clr_q <= 1'b0;
			end
		end
	end

	// every request goes to the back end so results stay in order
	assign push = look_s1;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q].req  <= req_s1;
			fifo_q[wr_ptr_q].id   <= id_s1;
			fifo_q[wr_ptr_q].team <= rd_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (q_pop) rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	assign q_valid = cnt_q != 2'd0;
	assign q_cmd = fifo_q[rd_ptr_q];
endmodule

### rtl/tgq_back.sv
// ----------------------------------------------------------------------------
// tgq_back: queue engine
// Carries out enqueue, dequeue and clear over the team and slot memories.
// ----------------------------------------------------------------------------
module tgq_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  tgq_pkg::cmd_t    q_cmd,
	output logic             q_pop,
	output logic             done,
	output logic [9:0]       done_id,
	output tgq_pkg::status_t done_st
);
	import tgq_pkg::*;

	logic [SLOT_W-1:0] head_mem [TEAMS];
	logic [SLOT_W-1:0] tail_mem [TEAMS];
	logic [ID_W-1:0]   memb_mem [CAPACITY];
	logic [SLOT_W-1:0] next_mem [CAPACITY];
	logic [TEAM_W-1:0] ord_mem  [TEAMS];
	logic [TEAMS-1:0]  wait_q;

	logic [SLOT_W-1:0] free_head_q;
	logic [CNT_W-1:0]  free_cnt_q, fresh_q;
	logic [TEAM_W-1:0] ord_head_q, ord_tail_q;
	logic [ORD_W-1:0]  ord_cnt_q;

	bk_state_t st_q, st_d;
	cmd_t cmd_q;

	// registered reads, addressed in IDLE
	logic [TEAM_W-1:0] ord_rd_q;
	logic [SLOT_W-1:0] fnext_q;     // next_mem[free_head]
	logic [SLOT_W-1:0] enq_tail_q;  // tail_mem[team of popped command]
	// dequeue reads: team head/tail after the order read, then slot id/link
	logic [SLOT_W-1:0] dq_head_q, dq_tail_q, dq_next_q;
	logic [ID_W-1:0]   dq_memb_q;
	logic [TEAM_W-1:0] dq_team_q;

	logic              enq_ok;
	logic [SLOT_W-1:0] enq_slot;
	assign enq_ok = free_cnt_q != '0 || fresh_q < CNT_W'(CAPACITY);
	assign enq_slot = free_cnt_q != '0 ? free_head_q : fresh_q[SLOT_W-1:0];

	// next state and outputs
	always_comb begin
		st_d = st_q;
		q_pop = 1'b0;
		done = 1'b0;
		done_id = '0;
		done_st = ST_OK;
		unique case (st_q)
			BK_IDLE: if (q_valid) begin
				q_pop = 1'b1;
				st_d = BK_EXEC;
			end
			BK_EXEC: begin
				unique case (cmd_q.req)
					REQ_ENQUEUE: begin
						done = 1'b1;
						if (!enq_ok) done_st = ST_FULL;
						st_d = BK_IDLE;
					end
					REQ_DEQUEUE: begin
						if (ord_cnt_q == '0) begin
							done = 1'b1;
							done_st = ST_EMPTY;
							st_d = BK_IDLE;
						end else
							st_d = BK_FETCH;
					end
					default: begin
						done = 1'b1;
						st_d = BK_IDLE;
					end
				endcase
			end
			BK_FETCH: st_d = BK_LINK;
			BK_LINK: begin
				done = 1'b1;
				done_id = dq_memb_q;
				st_d = BK_IDLE;
			end
			default: st_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= BK_IDLE;
		else st_q <= st_d;
	end

	// datapath memories
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_cmd;
			enq_tail_q <= tail_mem[q_cmd.team];
		end
		ord_rd_q <= ord_mem[ord_head_q];
		fnext_q <= next_mem[free_head_q];
		dq_team_q <= ord_rd_q;
		dq_head_q <= head_mem[ord_rd_q];
		dq_tail_q <= tail_mem[ord_rd_q];
		dq_memb_q <= memb_mem[dq_head_q];
		dq_next_q <= next_mem[dq_head_q];
		if (st_q == BK_EXEC && cmd_q.req == REQ_ENQUEUE && enq_ok) begin
			memb_mem[enq_slot] <= cmd_q.id;
			if (wait_q[cmd_q.team])
				next_mem[enq_tail_q] <= enq_slot;
			else begin
				head_mem[cmd_q.team] <= enq_slot;
				ord_mem[ord_tail_q] <= cmd_q.team;
			end
			tail_mem[cmd_q.team] <= enq_slot;
		end
		if (st_q == BK_LINK) begin
			if (dq_head_q != dq_tail_q) head_mem[dq_team_q] <= dq_next_q;
			next_mem[dq_head_q] <= free_head_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_q <= '0;
			free_head_q <= '0;
			free_cnt_q <= '0;
			fresh_q <= '0;
			ord_head_q <= '0;
			ord_tail_q <= '0;
			ord_cnt_q <= '0;
		end else if (st_q == BK_EXEC && cmd_q.req == REQ_CLEAR) begin
			wait_q <= '0;
			free_cnt_q <= '0;
			fresh_q <= '0;
			ord_head_q <= '0;
			ord_tail_q <= '0;
			ord_cnt_q <= '0;
		end else if (st_q == BK_EXEC && cmd_q.req == REQ_ENQUEUE && enq_ok) begin
			if (free_cnt_q != '0) begin
				free_head_q <= fnext_q;
				free_cnt_q <= free_cnt_q - 1'b1;
			end else
				fresh_q <= fresh_q + 1'b1;
			if (!wait_q[cmd_q.team]) begin
				wait_q[cmd_q.team] <= 1'b1;
				ord_tail_q <= ord_tail_q + 1'b1;
				ord_cnt_q <= ord_cnt_q + 1'b1;
			end
		end else if (st_q == BK_LINK) begin
			if (dq_head_q == dq_tail_q) begin
				wait_q[dq_team_q] <= 1'b0;
				ord_head_q <= ord_head_q + 1'b1;
				ord_cnt_q <= ord_cnt_q - 1'b1;
			end
			free_head_q <= dq_head_q;
			free_cnt_q <= free_cnt_q + 1'b1;
		end
	end
endmodule

### rtl/team_grouped_queue_unit.sv
// ----------------------------------------------------------------------------
// team_grouped_queue_unit: team queue with id-to-team map
// Front end with team lookup, two-entry command queue, queue engine.
// ----------------------------------------------------------------------------
// Raise start with a request while busy is low; exactly one result follows,
// shown for one cycle with done high. The receiver cannot stall. Every
// request, assign included, passes through the front end and the engine, so
// results leave in request order. After reset the front end zeroes the
// id-to-team map in a clearing pass over all 1024 entries with busy held high.
// For assign, enqueue, clear and an empty dequeue, done rises after team
// lookup, the queue, the engine's EXEC state and the output register; a
// dequeue that returns an id also reads the team order, then the team's
// head slot, then that slot's id and link. The front end takes no new
// request while one is under lookup; the engine takes a new command only
// from IDLE, and the two-entry queue absorbs the difference before busy
// holds the sender off.
module team_grouped_queue_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  tgq_pkg::req_t req_type,
	input  logic [9:0]    member_id,
	input  logic [5:0]    team_index,
	output logic          done,
	output logic [9:0]    out_id,
	output logic [1:0]    status
);
	import tgq_pkg::*;

	logic    q_valid, q_pop, bk_done;
	cmd_t    q_cmd;
	logic [9:0] bk_id;
	status_t bk_st;

	tgq_front u_front (
		.clk, .arst_n, .start, .busy, .req_type, .member_id, .team_index,
		.q_valid, .q_cmd, .q_pop
	);

	tgq_back u_back (
		.clk, .arst_n, .q_valid, .q_cmd, .q_pop,
		.done(bk_done), .done_id(bk_id), .done_st(bk_st)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
			out_id <= '0;
			status <= ST_OK;
		end else begin
			done <= bk_done;
			out_id <= bk_id;
			status <= bk_st;
		end
	end
endmodule

### rtl/tgq_checker.sv
// ----------------------------------------------------------------------------
// tgq_checker: port-level checks of the team grouped queue
// Watches request and result ports over time.
// ----------------------------------------------------------------------------
module tgq_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [9:0] out_id,
	input logic [1:0] status
);
	import tgq_pkg::*;

	a_no_code3: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> status != 2'd3) else $error("bad status");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> out_id == '0) else $error("id on error");
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("not busy after accept");
	a_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("results back to back");
endmodule

bind team_grouped_queue_unit tgq_checker u_chk (
	.clk, .arst_n, .start, .busy, .done, .out_id, .status
);

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for team_grouped_queue_unit
// Walks a short table of directed requests, an overflow fill and drain, then random bursts of
// assign/enqueue/dequeue/clear. A behavioral team queue predicts every result
// and each done pulse is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
	import tgq_pkg::*;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          start = 1'b0;
	logic          busy;
	req_t          req_type = REQ_ASSIGN;
	logic [9:0]    member_id = '0;
	logic [5:0]    team_index = '0;
	logic          done;
	logic [9:0]    out_id;
	logic [1:0]    status;

	team_grouped_queue_unit dut (.*);

	always #5 clk = ~clk;

	// predicted result of one request
	typedef struct {
		logic [9:0] id;
		status_t    st;
	} answer_t;

	answer_t answers_due[$];
	int      fail_cnt = 0;

	// behavioral team queue: one plain queue of ids per team plus team order
	logic [5:0] id_team [ID_SPACE];
	int         team_ids [TEAMS][$];
	int         team_line [$];
	int         used_slots;

	// work out the answer of one request and update the shadow queue
	function automatic answer_t team_queue_step(req_t rq, logic [9:0] id, logic [5:0] tm);
		answer_t a;
		int t;
		a.id = '0;
		a.st = ST_OK;
		case (rq)
			REQ_ASSIGN: id_team[id] = tm;
			REQ_ENQUEUE: begin
				if (used_slots >= CAPACITY) begin
					a.st = ST_FULL;
				end else begin
					t = id_team[id];
					if (team_ids[t].size() == 0) team_line.push_back(t);
					team_ids[t].push_back(id);
					used_slots++;
				end
			end
			REQ_DEQUEUE: begin
				if (team_line.size() == 0) begin
					a.st = ST_EMPTY;
				end else begin
					t = team_line[0];
					a.id = team_ids[t].pop_front();
					if (team_ids[t].size() == 0) void'(team_line.pop_front());
					used_slots--;
				end
			end
			default: begin
				foreach (team_ids[i]) team_ids[i].delete();
				team_line.delete();
				used_slots = 0;
			end
		endcase
		return a;
	endfunction

	// drive one item at a rising edge and return at the edge that accepts it;
	// start stays high, the caller lowers it before a gap. Typed-in
	// expectations are compared against the predictor so the table gets checked
	task automatic send_req(req_t rq, logic [9:0] id, logic [5:0] tm,
			bit typed = 0, logic [9:0] want_id = '0, status_t want_st = ST_OK);
		answer_t a;
		a = team_queue_step(rq, id, tm);
		if (typed && (a.id !== want_id || a.st !== want_st)) begin
			$error("table row %0d/%0d: expected id %0d st %0d, predictor %0d %0d",
				rq, id, want_id, want_st, a.id, a.st);
			fail_cnt++;
		end
		answers_due.push_back(a);
		start      <= 1'b1;
		req_type   <= rq;
		member_id  <= id;
		team_index <= tm;
		do @(negedge clk); while (busy);
		@(posedge clk);
	endtask

	// result checker: sampled in the middle of the done cycle
	always @(negedge clk) begin
		if (arst_n && done) begin
			if (answers_due.size() == 0) begin
				$error("unexpected result: out_id %0d status %0d", out_id, status);
				fail_cnt++;
			end else begin
				answer_t a;
				a = answers_due.pop_front();
				if (out_id !== a.id) begin
					$error("out_id: expected %0d, got %0d", a.id, out_id);
					fail_cnt++;
				end
				if (status !== a.st) begin
					$error("status: expected %0d, got %0d", a.st, status);
					fail_cnt++;
				end
			end
		end
	end

	// directed table: req, id, team, typed, expected id, expected status
	typedef struct {
		req_t rq; logic [9:0] id; logic [5:0] tm;
		bit typed; logic [9:0] eid; status_t est;
	} row_t;

	row_t rows[] = '{
		'{REQ_DEQUEUE, 10'd0,    6'd0,  1, 10'd0,    ST_EMPTY},
		'{REQ_ASSIGN,  10'd1023, 6'd63, 1, 10'd0,    ST_OK},
		'{REQ_ASSIGN,  10'd5,    6'd1,  1, 10'd0,    ST_OK},
		'{REQ_ASSIGN,  10'd6,    6'd63, 0, 10'd0,    ST_OK},
		'{REQ_ENQUEUE, 10'd0,    6'd0,  1, 10'd0,    ST_OK},
		'{REQ_ENQUEUE, 10'd5,    6'd0,  0, 10'd0,    ST_OK},
		'{REQ_ENQUEUE, 10'd1023, 6'd0,  0, 10'd0,    ST_OK},
		'{REQ_ENQUEUE, 10'd7,    6'd0,  0, 10'd0,    ST_OK},
		'{REQ_ENQUEUE, 10'd6,    6'd0,  0, 10'd0,    ST_OK},
		'{REQ_ENQUEUE, 10'd5,    6'd0,  0, 10'd0,    ST_OK},
		'{REQ_DEQUEUE, 10'd0,    6'd0,  1, 10'd0,    ST_OK},
		'{REQ_DEQUEUE, 10'd0,    6'd0,  1, 10'd7,    ST_OK},
		'{REQ_DEQUEUE, 10'd0,    6'd0,  1, 10'd5,    ST_OK},
		'{REQ_DEQUEUE, 10'd0,    6'd0,  0, 10'd0,    ST_OK},
		'{REQ_CLEAR,   10'd0,    6'd0,  1, 10'd0,    ST_OK},
		'{REQ_DEQUEUE, 10'd0,    6'd0,  1, 10'd0,    ST_EMPTY},
		'{REQ_ENQUEUE, 10'd1023, 6'd0,  0, 10'd0,    ST_OK},
		'{REQ_DEQUEUE, 10'd0,    6'd0,  1, 10'd1023, ST_OK},
		'{REQ_ASSIGN,  10'd1023, 6'd0,  0, 10'd0,    ST_OK}
	};

	// random request: mostly enqueue/dequeue with a small id pool so teams
	// regroup; rare clears so storage has a chance to fill up
	task automatic random_req(bit fill);
		int r;
		logic [9:0] id;
		r  = $urandom_range(99);
		id = ($urandom_range(3) == 0) ? 10'($urandom) : 10'($urandom_range(40));
		if (r < 10)
			send_req(REQ_ASSIGN, id, ($urandom_range(1)) ? 6'($urandom) : 6'($urandom_range(5)));
		else if (r < (fill ? 90 : 55))
			send_req(REQ_ENQUEUE, id, 6'($urandom));
		else if (r < 99)
			send_req(REQ_DEQUEUE, 10'($urandom), 6'($urandom));
		else
			send_req(REQ_CLEAR, 10'($urandom), 6'($urandom));
	endtask

	initial begin
		int sent;
		foreach (id_team[i]) id_team[i] = '0;
		used_slots = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i])
			send_req(rows[i].rq, rows[i].id, rows[i].tm,
				rows[i].typed, rows[i].eid, rows[i].est);

		// overflow: fill storage past capacity, then drain past empty
		for (int i = 0; i < CAPACITY + 3; i++)
			send_req(REQ_ENQUEUE, 10'($urandom), 6'($urandom));
		for (int i = 0; i < CAPACITY + 2; i++)
			send_req(REQ_DEQUEUE, 10'($urandom), 6'($urandom));

		// random part in bursts with random gaps; phases alternate between
		// filling and draining so full and empty both recur
		sent = 0;
		while (sent < 420) begin
			int burst;
			int gap;
			burst = $urandom_range(30, 1);
			for (int k = 0; k < burst; k++) begin
				random_req((sent / 200) % 2 == 0);
				sent++;
			end
			gap = ($urandom_range(3) != 0) ? $urandom_range(6) : 0;
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		start <= 1'b0;

		while (answers_due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_cnt == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// watchdog
	initial begin
		#20ms;
		$display("FAILED: results differ");
		$finish;
	end
endmodule

### filelist.f
rtl/tgq_pkg.sv
rtl/tgq_front.sv
rtl/tgq_back.sv
rtl/team_grouped_queue_unit.sv
rtl/tgq_checker.sv
tb/tb.sv
